// ----- rtl/sdc_pkg.sv -----
// Package for the short descriptor codec: descriptor kinds, attribute flag positions
// and the decode and encode functions. It depends on nothing else.
`default_nettype none

package sdc_pkg;

   typedef logic [2:0]  kind_type;
   typedef logic [14:0] attr_type;
   typedef logic [31:0] word_type;

   localparam logic       MODE_DECODE  = 1'b0;
   localparam logic       MODE_ENCODE  = 1'b1;
   localparam logic [1:0] LEVEL_FIRST  = 2'd1;
   localparam logic [1:0] LEVEL_SECOND = 2'd2;

   localparam kind_type KIND_TABLE = 3'd0;
   localparam kind_type KIND_SECT  = 3'd1;
   localparam kind_type KIND_SUPER = 3'd2;
   localparam kind_type KIND_LARGE = 3'd3;
   localparam kind_type KIND_SMALL = 3'd4;
   localparam kind_type KIND_INVAL = 3'd5;

   localparam int A_PR    = 0;
   localparam int A_PW    = 1;
   localparam int A_PX    = 2;
   localparam int A_UR    = 3;
   localparam int A_UW    = 4;
   localparam int A_UX    = 5;
   localparam int A_GLOB  = 6;
   localparam int A_SEC   = 7;
   localparam int A_TBL   = 8;
   localparam int A_VALID = 9;
   localparam int A_HID   = 10;
   localparam int A_HIDD  = 11;

   localparam logic [1:0] DESC_TYPE_LOW = 2'b01;

   localparam word_type MASK_TABLE = 32'hFFFF_FC00;
   localparam word_type MASK_SECT  = 32'hFFF0_0000;
   localparam word_type MASK_SUPER = 32'hFF00_0000;
   localparam word_type MASK_LARGE = 32'hFFFF_0000;
   localparam word_type MASK_SMALL = 32'hFFFF_F000;
   localparam word_type MASK_INVAL = 32'hFFFF_FFF0;

   localparam word_type DESC_HID   = 32'h0000_0004;
   localparam word_type DESC_HIDD  = 32'h0000_0008;
   localparam word_type DESC_TBL_S = 32'h0000_0001;
   localparam word_type DESC_TBL_N = 32'h0000_0009;

   function automatic kind_type classify(input logic first, input word_type d);
      kind_type k;
      k = KIND_INVAL;
      if (first) begin
         if (d[1:0] == DESC_TYPE_LOW) begin
            k = KIND_TABLE;
         end else if (d[1]) begin
            k = d[18] ? KIND_SUPER : KIND_SECT;
         end
      end else begin
         if (d[1:0] == DESC_TYPE_LOW) begin
            k = KIND_LARGE;
         end else if (d[1]) begin
            k = KIND_SMALL;
         end
      end
      return k;
   endfunction

   function automatic word_type base_of(input kind_type k, input word_type d);
      word_type m;
      unique case (k)
         KIND_TABLE: m = MASK_TABLE;
         KIND_SECT:  m = MASK_SECT;
         KIND_SUPER: m = MASK_SUPER;
         KIND_LARGE: m = MASK_LARGE;
         KIND_SMALL: m = MASK_SMALL;
         default:    m = MASK_INVAL;
      endcase
      return d & m;
   endfunction

   function automatic attr_type decode_flags(input kind_type k, input word_type d);
      attr_type a;
      a = '0;
      unique case (k)
         KIND_TABLE: begin
            a[A_TBL] = 1'b1;
            a[A_SEC] = ~d[3];
         end
         KIND_SECT: begin
            a[A_VALID] = 1'b1;
            a[A_PR]    = d[10];
            a[A_UR]    = d[10];
            a[A_PX]    = d[10] & ~d[4] & ~d[0];
            a[A_UX]    = d[10] & ~d[4];
            a[A_PW]    = ~d[15];
            a[A_UW]    = ~d[15];
            a[14:12]   = d[14:12] | {1'b0, d[3:2]};
            a[A_GLOB]  = ~d[17];
            a[A_SEC]   = ~d[19];
         end
         KIND_SMALL: begin
            a[A_VALID] = 1'b1;
            a[A_PR]    = d[4];
            a[A_UR]    = d[4];
            a[A_PX]    = d[4] & ~d[0];
            a[A_UX]    = d[4] & ~d[0];
            a[A_PW]    = ~d[9];
            a[A_UW]    = ~d[9];
            a[14:12]   = d[8:6] | {1'b0, d[3:2]};
            a[A_GLOB]  = ~d[11];
         end
         KIND_INVAL: begin
            a[A_HID]  = d[2];
            a[A_HIDD] = ~d[2] & d[3];
         end
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic word_type encode_desc(input logic first, input logic pxn,
                                            input attr_type a_in);
      attr_type   a;
      word_type   d;
      logic [2:0] t;
      a = a_in;
      d = '0;
      t = a_in[14:12];
      if (a[A_HID]) begin
         d = DESC_HID;
      end else if (a[A_HIDD]) begin
         d = DESC_HIDD;
      end else if (first && a[A_TBL]) begin
         d = a[A_SEC] ? DESC_TBL_S : DESC_TBL_N;
      end else if (a[A_VALID]) begin
         if (a[A_PX] | a[A_PW]) begin
            a[A_PR] = 1'b1;
         end
         if (a[A_UX] | a[A_UW]) begin
            a[A_UR] = 1'b1;
         end
         if (a[A_UR]) begin
            a[A_PR] = 1'b1;
         end
         if (a[A_UW]) begin
            a[A_PW] = 1'b1;
         end
         d[1] = 1'b1;
         d[2] = t[0];
         d[3] = t[1];
         if (first) begin
            d[16] = 1'b1;
            d[4]  = ~(a[A_PX] | a[A_UX]);
            d[0]  = pxn & ~a[A_PX];
            d[11] = a[A_UR];
            d[15] = ~a[A_PW];
            d[10] = a[A_UR] | a[A_PR];
            d[17] = ~a[A_GLOB];
            d[19] = ~a[A_SEC];
            d[12] = t[2];
         end else begin
            d[10] = 1'b1;
            d[0]  = ~(a[A_PX] | a[A_UX]);
            d[5]  = a[A_UR];
            d[9]  = ~a[A_PW];
            d[4]  = a[A_UR] | a[A_PR];
            d[11] = ~a[A_GLOB];
            d[6]  = t[2];
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/short_descriptor_codec.sv -----
// Short descriptor codec top level: request register, decode/encode logic, result register.
// Depends on sdc_pkg for kinds, flag positions and the codec functions.
//
// Usage. Requests arrive on the req_ channel (valid/stall); a beat is taken at a rising
// edge with req_valid high and req_stall low. With req_mode low the descriptor in
// req_descriptor_in is decoded at req_level into a kind, a physical base and attribute
// flags; with req_mode high the flags in req_attr_in are built into a descriptor word.
// Each request gives exactly one result beat on the rsp_ channel.
// A taken beat goes into the request register and then, through the codec logic, into
// the result register, from which it is shown on rsp_.
// Throughput is one beat per cycle while rsp_stall is low; the request register and the
// result register are the two stages, with the codec logic between them.
// When the receiver holds rsp_stall, the result register holds its beat and the request
// register may still take one more beat; req_stall rises only when both stages are full.
// csr_write_en writes csr_write_data into the privileged-execute-never enable; the user
// must change it only while no beats are in flight, as the block does not enforce this.
// Synchronous reset empties both stages and clears the enable.
`default_nettype none

module short_descriptor_codec (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [1:0]  req_level,
   input  wire logic [31:0] req_descriptor_in,
   input  wire logic [14:0] req_attr_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_desc_kind,
   output logic [31:0]      rsp_phys_base,
   output logic [14:0]      rsp_attr_out,
   output logic [31:0]      rsp_descriptor_out
);

   logic                pxn_enable_ff;
   logic                s1_valid_ff,  s1_valid_in;
   logic                s1_mode_ff;
   logic [1:0]          s1_level_ff;
   sdc_pkg::word_type   s1_desc_ff;
   sdc_pkg::attr_type   s1_attr_ff;
   logic                out_valid_ff, out_valid_in;
   sdc_pkg::kind_type   out_kind_ff,  out_kind_in;
   sdc_pkg::word_type   out_base_ff,  out_base_in;
   sdc_pkg::attr_type   out_attr_ff,  out_attr_in;
   sdc_pkg::word_type   out_desc_ff,  out_desc_in;
   logic                req_take;
   logic                s1_move;
   logic                first;
   sdc_pkg::kind_type   kind;

   assign s1_move   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & out_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_move);
   assign out_valid_in = s1_move | (out_valid_ff & rsp_stall);

   always_comb begin
      first = (s1_level_ff == sdc_pkg::LEVEL_FIRST);
      kind  = sdc_pkg::classify(first, s1_desc_ff);
      if (s1_mode_ff == sdc_pkg::MODE_ENCODE) begin
         out_kind_in = sdc_pkg::KIND_TABLE;
         out_base_in = '0;
         out_attr_in = '0;
         out_desc_in = sdc_pkg::encode_desc(first, pxn_enable_ff, s1_attr_ff);
      end else begin
         out_kind_in = kind;
         out_base_in = sdc_pkg::base_of(kind, s1_desc_ff);
         out_attr_in = sdc_pkg::decode_flags(kind, s1_desc_ff);
         out_desc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pxn_enable_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            pxn_enable_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_mode;
         s1_level_ff <= req_level;
         s1_desc_ff  <= req_descriptor_in;
         s1_attr_ff  <= req_attr_in;
      end
      if (s1_move) begin
         out_kind_ff <= out_kind_in;
         out_base_ff <= out_base_in;
         out_attr_ff <= out_attr_in;
         out_desc_ff <= out_desc_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_desc_kind      = out_kind_ff;
   assign rsp_phys_base      = out_base_ff;
   assign rsp_attr_out       = out_attr_ff;
   assign rsp_descriptor_out = out_desc_ff;

   assert property (@(posedge clock) reset |=> !s1_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("request stalled while a stage is free");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_stall |=> out_valid_ff)
      else $error("held beat did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_desc_ff != '0 |-> out_base_ff == '0 && out_attr_ff == '0
         && out_kind_ff == sdc_pkg::KIND_TABLE)
      else $error("encode result carries decode fields");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_attr_ff[sdc_pkg::A_VALID]
         |-> out_kind_ff == sdc_pkg::KIND_SECT || out_kind_ff == sdc_pkg::KIND_SMALL)
      else $error("valid flag on a kind that has no flags");

endmodule

`default_nettype wire
